[hw/rtl/rts_pkg.sv]
// shared types, constants and helpers for the rotated table search block
package rts_pkg;

   localparam int IDX_W           = 10;
   localparam int DATA_W          = 32;
   localparam int SPAN_W          = IDX_W + 2;
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_SEARCH,
      KIND_EMPTY
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [IDX_W-1:0]          write_index;
      logic signed [DATA_W-1:0]  entry_value;
      logic signed [DATA_W-1:0]  search_key;
      logic [IDX_W-1:0]          low_index;
      logic [IDX_W-1:0]          high_index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_port_type;

   function automatic logic idx_in_table(input logic [IDX_W-1:0] idx, input int depth);
      return int'(idx) < depth;
   endfunction

endpackage

[hw/rtl/rts_if.sv]
// request and response channel interfaces
interface rts_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  opcode;
   logic [rts_pkg::IDX_W-1:0]             write_index;
   logic signed [rts_pkg::DATA_W-1:0]     entry_value;
   logic signed [rts_pkg::DATA_W-1:0]     search_key;
   logic [rts_pkg::IDX_W-1:0]             low_index;
   logic [rts_pkg::IDX_W-1:0]             high_index;

   modport source (output valid, opcode, write_index, entry_value, search_key,
                   low_index, high_index, input ready);
   modport sink   (input valid, opcode, write_index, entry_value, search_key,
                   low_index, high_index, output ready);
endinterface

interface rts_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [rts_pkg::IDX_W-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

[hw/rtl/rts_ram.sv]
// generic single write port, single read port ram with registered read
module rts_ram #(
   parameter int WIDTH = rts_pkg::DATA_W,
   parameter int DEPTH = rts_pkg::TABLE_DEPTH_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rts_front.sv]
// front end: accepts items, classifies them and queues them for the back end
module rts_front #(
   parameter int TABLE_DEPTH = rts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rts_req_if.sink               req_ch,
   output rts_pkg::cmd_port_type cmd_port,
   input  logic                  cmd_pop
);

   localparam int QD    = rts_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNT_W = $clog2(QD + 1);

   rts_pkg::cmd_type   queue_ff [QD];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   rts_pkg::cmd_type   cmd_new;
   logic               accept;
   logic               push;
   logic               pop;

   assign req_ch.ready = (count_ff != CNT_W'(QD));
   assign accept       = req_ch.valid && req_ch.ready;

   // classify
   always_comb begin
      cmd_new.write_index = req_ch.write_index;
      cmd_new.entry_value = req_ch.entry_value;
      cmd_new.search_key  = req_ch.search_key;
      cmd_new.low_index   = req_ch.low_index;
      cmd_new.high_index  = req_ch.high_index;
      if (req_ch.opcode == rts_pkg::OP_WRITE) begin
         cmd_new.kind = rts_pkg::KIND_WRITE;
      end else if (req_ch.low_index > req_ch.high_index) begin
         cmd_new.kind = rts_pkg::KIND_EMPTY;
      end else begin
         cmd_new.kind = rts_pkg::KIND_SEARCH;
      end
   end

   // writes beyond the table are dropped here
   assign push = accept && !(req_ch.opcode == rts_pkg::OP_WRITE &&
                             !rts_pkg::idx_in_table(req_ch.write_index, TABLE_DEPTH));
   assign pop  = cmd_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QD - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QD - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_port.valid = (count_ff != '0);
   assign cmd_port.cmd   = queue_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QD))
      else $error("queue count beyond depth");

   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(QD) && !pop) |=> count_ff == CNT_W'(QD))
      else $error("full queue changed without a pop");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(1) && pop && !push) |=> !cmd_port.valid)
      else $error("queue not empty after last pop");

endmodule

[hw/rtl/rts_back.sv]
// back end: table writes and the probe sequencer of the rotated search
module rts_back #(
   parameter int TABLE_DEPTH = rts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rts_pkg::cmd_port_type cmd_port,
   output logic                  cmd_pop,
   rts_rsp_if.source             rsp_ch
);

   localparam int IDX_W  = rts_pkg::IDX_W;
   localparam int DATA_W = rts_pkg::DATA_W;
   localparam int SPAN_W = rts_pkg::SPAN_W;
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MID,
      ST_LO,
      ST_HI,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [SPAN_W-1:0]  lo_ff, lo_in;
   logic signed [SPAN_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]          mid_ff, mid_in;
   logic signed [DATA_W-1:0]  key_ff, key_in;
   logic signed [DATA_W-1:0]  vm_ff, vm_in;
   logic                      rd_ok_ff, rd_ok_in;
   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]          rsp_pos_ff, rsp_pos_in;

   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [IDX_W-1:0]          rd_idx;
   logic [DATA_W-1:0]         ram_rd_data;
   logic signed [DATA_W-1:0]  rd_val;
   logic signed [SPAN_W-1:0]  span_sum;
   logic signed [SPAN_W-1:0]  mid_s;
   logic                      out_free;

   rts_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(cmd_port.cmd.write_index)),
      .wr_data (cmd_port.cmd.entry_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_W'(rd_idx)),
      .rd_data (ram_rd_data)
   );

   // positions beyond the table read as zero
   assign rd_val   = rd_ok_ff ? $signed(ram_rd_data) : '0;
   assign span_sum = lo_ff + hi_ff;
   assign mid_s    = $signed({2'b00, mid_ff});
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_port.valid;
   assign ram_wr_en = cmd_pop && (cmd_port.cmd.kind == rts_pkg::KIND_WRITE);
   assign rd_ok_in  = ram_rd_en ? rts_pkg::idx_in_table(rd_idx, TABLE_DEPTH) : rd_ok_ff;

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      vm_in        = vm_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ram_rd_en    = 1'b0;
      rd_idx       = mid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_port.valid) begin
               unique case (cmd_port.cmd.kind)
                  rts_pkg::KIND_SEARCH: begin
                     lo_in    = $signed({2'b00, cmd_port.cmd.low_index});
                     hi_in    = $signed({2'b00, cmd_port.cmd.high_index});
                     key_in   = cmd_port.cmd.search_key;
                     state_in = ST_CHECK;
                  end
                  rts_pkg::KIND_EMPTY: begin
                     found_in = 1'b0;
                     pos_in   = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (lo_ff > hi_ff) begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = ST_DONE;
            end else begin
               mid_in    = span_sum[IDX_W:1];
               rd_idx    = span_sum[IDX_W:1];
               ram_rd_en = 1'b1;
               state_in  = ST_MID;
            end
         end
         ST_MID: begin
            if (rd_val == key_ff) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               state_in = ST_DONE;
            end else begin
               vm_in     = rd_val;
               rd_idx    = lo_ff[IDX_W-1:0];
               ram_rd_en = 1'b1;
               state_in  = ST_LO;
            end
         end
         ST_LO: begin
            if (rd_val <= vm_ff) begin
               if (key_ff >= rd_val && key_ff < vm_ff) begin
                  hi_in = mid_s - SPAN_W'(1);
               end else begin
                  lo_in = mid_s + SPAN_W'(1);
               end
               state_in = ST_CHECK;
            end else begin
               rd_idx    = hi_ff[IDX_W-1:0];
               ram_rd_en = 1'b1;
               state_in  = ST_HI;
            end
         end
         ST_HI: begin
            if (key_ff > vm_ff && key_ff <= rd_val) begin
               lo_in = mid_s + SPAN_W'(1);
            end else begin
               hi_in = mid_s - SPAN_W'(1);
            end
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      vm_ff        <= vm_in;
      rd_ok_ff     <= rd_ok_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.found    = rsp_found_ff;
   assign rsp_ch.position = rsp_pos_ff;

   a_mid_after_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MID) |-> ($past(state_ff) == ST_CHECK))
      else $error("middle probe without span check");

   a_mid_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MID) |-> (mid_s >= lo_ff && mid_s <= hi_ff))
      else $error("probe outside the span");

   a_lo_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> !lo_ff[SPAN_W-1])
      else $error("low bound went negative");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished search did not reach the output register");

   a_write_in_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE && !ram_rd_en))
      else $error("table write outside idle");

endmodule

[hw/rtl/rotated_table_search_top.sv]
// top level of the rotated table search block
// a write item is taken by the back end in its idle state and gives no result
// a search steps through span check, middle probe, low probe and, when needed, high probe per halving step
// at most 11 probes for a 1024-entry span; an empty span gives a not-found result with no probe
// one item at a time in the back end; each probe is bound by the single table read port
// reset clears the queue, the sequencer and the output register; table undefined until written
module rotated_table_search_top #(
   parameter int TABLE_DEPTH = rts_pkg::TABLE_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   rts_req_if.sink   req_ch,
   rts_rsp_if.source rsp_ch
);

   rts_pkg::cmd_port_type cmd_port;
   logic                  cmd_pop;

   rts_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cmd_port (cmd_port),
      .cmd_pop  (cmd_pop)
   );

   rts_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_port (cmd_port),
      .cmd_pop  (cmd_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

[verif/testbench.sv]
// self-checking testbench for the rotated table search block
module testbench;
   import rts_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int ITEM_TARGET  = 1150;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam longint MIN32 = -64'sd2147483648;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint SPAN32 = 64'sd4294967296;

   typedef struct packed {
      logic                     opcode;
      logic [IDX_W-1:0]         write_index;
      logic signed [DATA_W-1:0] entry_value;
      logic signed [DATA_W-1:0] search_key;
      logic [IDX_W-1:0]         low_index;
      logic [IDX_W-1:0]         high_index;
   } table_op_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
   } search_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] cycle_count = '0;
   logic        calm;

   rts_req_if req_ch ();
   rts_rsp_if rsp_ch ();

   rotated_table_search_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   table_op_type             pending_ops [$];
   search_result_type        expected_results [$];
   logic signed [DATA_W-1:0] plan_value [0:DEPTH-1];
   bit                       plan_written [0:DEPTH-1];
   logic signed [DATA_W-1:0] live_value [0:DEPTH-1];
   table_op_type             next_op;

   int items_planned = 0, items_accepted = 0, error_count = 0;
   int writes_seen = 0, searches_seen = 0, hits_seen = 0, empty_spans = 0;
   int results_seen = 0, holds_done = 0;
   int gap_left = 0, stall_left = 0, hold_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // quiet stretches with no gaps or stalls
   assign calm = cycle_count[9:8] == 2'b11;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic signed [DATA_W-1:0] entry_at(input bit on_plan, input int idx);
      return on_plan ? plan_value[idx] : live_value[idx];
   endfunction

   // halving search over a rotated run; clean drops when a probe touches an unwritten entry
   function automatic void search_table(input bit on_plan,
                                        input logic signed [DATA_W-1:0] key,
                                        input int lo_start, input int hi_start,
                                        output search_result_type res, output bit clean);
      int lo, hi, mid;
      logic signed [DATA_W-1:0] v_mid, v_lo, v_hi;
      lo    = lo_start;
      hi    = hi_start;
      res   = '0;
      clean = 1'b1;
      while (lo <= hi && !res.found) begin
         mid = (lo + hi) / 2;
         if (on_plan) clean = clean & plan_written[lo] & plan_written[mid] & plan_written[hi];
         v_mid = entry_at(on_plan, mid);
         v_lo  = entry_at(on_plan, lo);
         v_hi  = entry_at(on_plan, hi);
         if (v_mid == key) begin
            res.found    = 1'b1;
            res.position = IDX_W'(mid);
         end else if (v_lo <= v_mid) begin
            if (key >= v_lo && key < v_mid) hi = mid - 1;
            else lo = mid + 1;
         end else begin
            if (key > v_mid && key <= v_hi) lo = mid + 1;
            else hi = mid - 1;
         end
      end
   endfunction

   task automatic queue_write(input int idx, input logic signed [DATA_W-1:0] val);
      table_op_type op;
      op.opcode         = OP_WRITE;
      op.write_index    = IDX_W'(idx);
      op.entry_value    = val;
      op.search_key     = $urandom;
      op.low_index      = IDX_W'($urandom);
      op.high_index     = IDX_W'($urandom);
      plan_value[idx]   = val;
      plan_written[idx] = 1'b1;
      pending_ops.push_back(op);
      items_planned++;
   endtask

   task automatic queue_search(input logic signed [DATA_W-1:0] key, input int lo, input int hi);
      table_op_type op;
      op.opcode      = OP_SEARCH;
      op.write_index = IDX_W'($urandom);
      op.entry_value = $urandom;
      op.search_key  = key;
      op.low_index   = IDX_W'(lo);
      op.high_index  = IDX_W'(hi);
      pending_ops.push_back(op);
      items_planned++;
   endtask

   task automatic fill_region(input int base, input int len, input bit sorted);
      longint vals [0:127];
      longint step_cap, room, cursor, pick, offset;
      int rot;
      if (sorted) begin
         case ($urandom_range(0, 3))
            0: step_cap = 1;
            1: step_cap = 1000;
            2: step_cap = 1048576;
            default: step_cap = SPAN32 / (len + 1);
         endcase
         room   = SPAN32 - 1 - len * step_cap;
         pick   = $urandom;
         cursor = MIN32 + pick % (room + 1);
         if ($urandom_range(0, 5) == 0) cursor = MIN32;
         for (int i = 0; i < len; i++) begin
            vals[i] = cursor;
            cursor += $urandom_range(32'(step_cap), 1);
         end
         if ($urandom_range(0, 5) == 0) begin
            offset = MAX32 - vals[len-1];
            for (int i = 0; i < len; i++) vals[i] += offset;
         end
      end else begin
         // unsorted contents, small values give duplicates
         for (int i = 0; i < len; i++)
            vals[i] = $urandom_range(0, 1) ? longint'($signed($urandom))
                                           : longint'($urandom_range(0, 6)) - 3;
      end
      rot = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) queue_write(base + i, DATA_W'(vals[(i + rot) % len]));
   endtask

   task automatic search_region(input int base, input int len);
      logic signed [DATA_W-1:0] key, known;
      int lo, hi;
      search_result_type res;
      bit clean;
      known = plan_value[base + $urandom_range(0, len - 1)];
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: key = known;
         6: key = known + 1;
         7: key = known - 1;
         8: key = $urandom;
         default: key = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
      lo = base;
      hi = base + len - 1;
      case ($urandom_range(0, 9))
         7, 8: begin
            lo = base + $urandom_range(0, len - 1);
            hi = base + $urandom_range(0, len - 1);
         end
         9: begin
            lo = $urandom_range(0, DEPTH - 1);
            hi = $urandom_range(0, DEPTH - 1);
         end
         default: ;
      endcase
      search_table(1'b1, key, lo, hi, res, clean);
      if (!clean) begin
         lo = base;
         hi = base + len - 1;
      end
      queue_search(key, lo, hi);
   endtask

   task automatic predict_item();
      search_result_type res;
      bit clean;
      items_accepted++;
      if (req_ch.opcode == OP_WRITE) begin
         live_value[req_ch.write_index] = req_ch.entry_value;
         writes_seen++;
      end else begin
         search_table(1'b0, req_ch.search_key, int'(req_ch.low_index),
                      int'(req_ch.high_index), res, clean);
         expected_results.push_back(res);
         searches_seen++;
         if (req_ch.low_index > req_ch.high_index) empty_spans++;
      end
   endtask

   task automatic check_result();
      search_result_type want;
      results_seen++;
      if (expected_results.size() == 0) begin
         $error("result found=%0d position=%0d with no search pending",
                rsp_ch.found, rsp_ch.position);
         error_count++;
      end else begin
         want = expected_results.pop_front();
         if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            error_count++;
         end
         if (rsp_ch.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
            error_count++;
         end
         if (want.found) hits_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.opcode      <= OP_WRITE;
         req_ch.write_index <= '0;
         req_ch.entry_value <= '0;
         req_ch.search_key  <= '0;
         req_ch.low_index   <= '0;
         req_ch.high_index  <= '0;
         gap_left           <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_item();
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               next_op = pending_ops.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.opcode      <= next_op.opcode;
               req_ch.write_index <= next_op.write_index;
               req_ch.entry_value <= next_op.entry_value;
               req_ch.search_key  <= next_op.search_key;
               req_ch.low_index   <= next_op.low_index;
               req_ch.high_index  <= next_op.high_index;
               gap_left <= (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
         hold_left    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_result();
         if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if ((holds_done == 0 && results_seen >= 40) ||
                      (holds_done == 1 && results_seen >= 150)) begin
            // long hold-off so the block backs up into its input
            holds_done   <= holds_done + 1;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left   <= pick_gap() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int region_base, region_len;

      // rotated run at the bottom of the table, minimum value inside it
      queue_write(0, 40);
      queue_write(1, 50);
      queue_write(2, 32'sh80000000);
      queue_write(3, -5);
      queue_write(4, 0);
      queue_write(5, 10);
      queue_write(6, 20);
      queue_write(7, 30);
      // rotated run at the top of the table with both extremes
      queue_write(1020, 100);
      queue_write(1021, 32'sh7fffffff);
      queue_write(1022, 32'sh80000000);
      queue_write(1023, 7);
      queue_search(-5, 0, 7);
      queue_search(50, 0, 7);
      queue_search(35, 0, 7);
      queue_search(32'sh80000000, 0, 7);
      queue_search(40, 0, 0);
      queue_search(40, 5, 2);
      queue_search(40, 1023, 0);
      queue_search(32'sh7fffffff, 1020, 1023);
      queue_search(32'sh80000000, 1020, 1023);
      queue_search(7, 1023, 1023);
      queue_search(8, 1020, 1023);
      queue_search(32'sh7fffffff, 0, 7);

      while (items_planned < ITEM_TARGET) begin
         region_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 120)
                                                   : $urandom_range(1, 32);
         region_base = $urandom_range(0, DEPTH - region_len);
         fill_region(region_base, region_len, $urandom_range(0, 6) != 0);
         repeat ($urandom_range(3, 10)) search_region(region_base, region_len);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < items_planned) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d writes and %0d searches: %0d found, %0d missed, %0d with an empty span",
               writes_seen, searches_seen, hits_seen, searches_seen - hits_seen, empty_spans);
      $display("rotated and unsorted runs, random gaps both sides, %0d long output hold-offs",
               holds_done);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
